// ----- rtl/rclc_pkg.sv -----
// ----------------------------------------------------------------------------
// rclc_pkg: shared types and constants of the resistance calculation unit
// Holds the payload structs of the channels, the stage records passed between
// the pipeline modules, register codes and the range resistor table.
// ----------------------------------------------------------------------------
package rclc_pkg;

  // Build-time constants of the measurement front end.
  localparam int RangeCount = 7;
  localparam int AdcBits    = 12;

  localparam int NumCodes  = 7;
  localparam int NumActive = (RangeCount > NumCodes) ? NumCodes :
                             ((RangeCount < 1) ? 1 : RangeCount);

  localparam int CodeW  = 12;
  localparam int RangeW = 3;
  localparam int ResW   = 25;
  localparam int UnitW  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int NumW   = 32;
  localparam int TabW   = 24;
  localparam int ProdW  = TabW + NumW;
  localparam int QuoW   = ResW;

  localparam logic [CodeW-1:0] CodeMask =
      (AdcBits >= CodeW) ? {CodeW{1'b1}} : CodeW'((1 << AdcBits) - 1);

  localparam logic [QuoW-1:0] MinTenths   = QuoW'(10);
  localparam logic [QuoW-1:0] MaxTenths   = QuoW'(20000000);
  localparam logic [QuoW-1:0] OhmDecLimit = QuoW'(10000);
  localparam logic [QuoW-1:0] OhmLimit    = QuoW'(1000000);
  localparam logic [QuoW-1:0] KohmLimit   = QuoW'(10000000);

  localparam logic [15:0] UpperSumRst = 16'd20050;
  localparam logic [15:0] LowerRst    = 16'd10060;
  localparam logic [11:0] LevelRst    = 12'd2048;
  localparam logic [11:0] Floor0Rst   = 12'd3600;
  localparam logic [11:0] Floor1Rst   = 12'd3200;
  localparam logic [11:0] Floor2Rst   = 12'd2600;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUpperSum    = 3'd0,
    CfgLower       = 3'd1,
    CfgSwitchLevel = 3'd2,
    CfgFloor0      = 3'd3,
    CfgFloor1      = 3'd4,
    CfgFloor2      = 3'd5
  } cfg_idx_e;

  typedef enum logic [UnitW-1:0] {
    UnitInvalid = 3'd0,
    UnitOhmDec  = 3'd1,
    UnitOhm     = 3'd2,
    UnitKohm    = 3'd3,
    UnitMohm    = 3'd4
  } unit_e;

  typedef struct packed {
    logic [CodeW-1:0] ref_code;
    logic [CodeW-1:0] range_code_0;
    logic [CodeW-1:0] range_code_1;
    logic [CodeW-1:0] range_code_2;
    logic [CodeW-1:0] range_code_3;
    logic [CodeW-1:0] range_code_4;
    logic [CodeW-1:0] range_code_5;
    logic [CodeW-1:0] range_code_6;
  } meas_t;

  typedef struct packed {
    logic [RangeW-1:0] chosen_range;
    logic [ResW-1:0]   resistance_tenths;
    logic [UnitW-1:0]  unit_class;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [15:0] upper_sum;
    logic [15:0] lower;
    logic [11:0] switch_level;
    logic [11:0] floor0;
    logic [11:0] floor1;
    logic [11:0] floor2;
  } cfg_t;

  // Record after range selection.
  typedef struct packed {
    logic [RangeW-1:0] sel;
    logic [CodeW-1:0]  ref_code;
    logic [CodeW-1:0]  code;
  } sel_st_t;

  // Record handed from the arithmetic front to the divider.
  typedef struct packed {
    logic [RangeW-1:0] sel;
    logic              ok;
    logic [NumW-1:0]   den;
    logic [ProdW-1:0]  prod;
  } prod_st_t;

  // Record of one divider stage.
  typedef struct packed {
    logic [RangeW-1:0] sel;
    logic              ok;
    logic [NumW-1:0]   den;
    logic [NumW-1:0]   rem;
    logic [QuoW-1:0]   low;
    logic [QuoW-1:0]   quo;
  } div_st_t;

  // Range resistors in tenths of an ohm.
  function automatic logic [TabW-1:0] range_tenths(input logic [RangeW-1:0] sel);
    logic [TabW-1:0] r;
    unique case (sel)
      3'd0:    r = TabW'(5074);
      3'd1:    r = TabW'(21730);
      3'd2:    r = TabW'(50530);
      3'd3:    r = TabW'(100200);
      3'd4:    r = TabW'(1009000);
      3'd5:    r = TabW'(4686000);
      default: r = TabW'(10030000);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/rclc_stream_if.sv -----
// ----------------------------------------------------------------------------
// rclc_stream_if: valid/ready channel
// Carries one payload per request; a request moves when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface rclc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/rclc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rclc_cfg_regs: configuration register file
// Takes register writes from the configuration channel; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module rclc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  rclc_stream_if.sink       cfg_i,
  output rclc_pkg::cfg_t    cfg_o
);
  import rclc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CfgUpperSum:    cfg_d.upper_sum    = cfg_i.payload.data;
        CfgLower:       cfg_d.lower        = cfg_i.payload.data;
        CfgSwitchLevel: cfg_d.switch_level = cfg_i.payload.data[11:0];
        CfgFloor0:      cfg_d.floor0       = cfg_i.payload.data[11:0];
        CfgFloor1:      cfg_d.floor1       = cfg_i.payload.data[11:0];
        CfgFloor2:      cfg_d.floor2       = cfg_i.payload.data[11:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_sum    <= UpperSumRst;
      cfg_q.lower        <= LowerRst;
      cfg_q.switch_level <= LevelRst;
      cfg_q.floor0       <= Floor0Rst;
      cfg_q.floor1       <= Floor1Rst;
      cfg_q.floor2       <= Floor2Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/rclc_select.sv -----
// ----------------------------------------------------------------------------
// rclc_select: range selection stage
// Picks the lowest range whose code is above the switch level, applies the
// floor step-up of the three lowest ranges and registers the chosen code.
// ----------------------------------------------------------------------------
module rclc_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  rclc_pkg::meas_t    meas_i,
  input  rclc_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output rclc_pkg::sel_st_t  st_o
);
  import rclc_pkg::*;

  logic [CodeW-1:0]  code [NumCodes];
  logic [RangeW-1:0] sel;
  logic              valid_q;
  sel_st_t           st_q, st_d;

  assign code[0] = meas_i.range_code_0 & CodeMask;
  assign code[1] = meas_i.range_code_1 & CodeMask;
  assign code[2] = meas_i.range_code_2 & CodeMask;
  assign code[3] = meas_i.range_code_3 & CodeMask;
  assign code[4] = meas_i.range_code_4 & CodeMask;
  assign code[5] = meas_i.range_code_5 & CodeMask;
  assign code[6] = meas_i.range_code_6 & CodeMask;

  always_comb begin
    sel = RangeW'(NumActive - 1);
    for (int i = NumActive - 1; i >= 0; i--) begin
      if (code[i] > cfg_i.switch_level) sel = RangeW'(i);
    end
    priority if (sel == 3'd0 && code[0] < cfg_i.floor0) sel = 3'd1;
    else if (sel == 3'd1 && code[1] < cfg_i.floor1) sel = 3'd2;
    else if (sel == 3'd2 && code[2] < cfg_i.floor2) sel = 3'd3;
    else sel = sel;
    if (sel >= RangeW'(NumActive)) sel = RangeW'(NumActive - 1);

    st_d.sel      = sel;
    st_d.ref_code = meas_i.ref_code & CodeMask;
    st_d.code     = code[sel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ----- rtl/rclc_arith.sv -----
// ----------------------------------------------------------------------------
// rclc_arith: numerator and denominator stages
// Four stages: the two divider products, their difference and sign test,
// the range resistor product, and the quotient overflow test.
// ----------------------------------------------------------------------------
module rclc_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  rclc_pkg::sel_st_t   st_i,
  input  rclc_pkg::cfg_t      cfg_i,
  output logic                valid_o,
  output rclc_pkg::prod_st_t  st_o
);
  import rclc_pkg::*;

  logic [3:0] valid_q;

  // Stage two: both products of the divider ratio.
  logic [RangeW-1:0] s2_sel_q;
  logic [NumW-1:0]   s2_num_a_q, s2_num_b_q;
  // Stage three: difference, kept only when positive with a nonzero code term.
  logic [RangeW-1:0] s3_sel_q;
  logic              s3_ok_q;
  logic [NumW-1:0]   s3_diff_q, s3_den_q;
  // Stage four: scaled by the range resistor.
  logic [RangeW-1:0] s4_sel_q;
  logic              s4_ok_q;
  logic [NumW-1:0]   s4_den_q;
  logic [ProdW-1:0]  s4_prod_q;
  // Stage five: the quotient must fit the result width.
  prod_st_t          s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_sel_q   <= st_i.sel;
      s2_num_a_q <= NumW'(st_i.ref_code) * NumW'(cfg_i.upper_sum);
      s2_num_b_q <= NumW'(st_i.code) * NumW'(cfg_i.lower);

      s3_sel_q  <= s2_sel_q;
      s3_ok_q   <= (s2_num_b_q != '0) && (s2_num_a_q > s2_num_b_q);
      s3_diff_q <= s2_num_a_q - s2_num_b_q;
      s3_den_q  <= s2_num_b_q;

      s4_sel_q  <= s3_sel_q;
      s4_ok_q   <= s3_ok_q;
      s4_den_q  <= s3_den_q;
      s4_prod_q <= ProdW'(range_tenths(s3_sel_q)) * ProdW'(s3_diff_q);

      s5_q.sel  <= s4_sel_q;
      s5_q.ok   <= s4_ok_q && (NumW'(s4_prod_q[ProdW-1:QuoW]) < s4_den_q);
      s5_q.den  <= s4_den_q;
      s5_q.prod <= s4_prod_q;
    end
  end

  assign valid_o = valid_q[3];
  assign st_o    = s5_q;

endmodule

// ----- rtl/rclc_div.sv -----
// ----------------------------------------------------------------------------
// rclc_div: pipelined restoring divider
// One quotient bit per stage; the first partial remainder is the upper part
// of the product, which the overflow test requires to be below the divisor.
// ----------------------------------------------------------------------------
module rclc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  rclc_pkg::prod_st_t  st_i,
  output logic                valid_o,
  output rclc_pkg::div_st_t   st_o
);
  import rclc_pkg::*;

  localparam int Steps = QuoW;

  logic [Steps-1:0] valid_q;
  div_st_t          st_q   [Steps];
  div_st_t          cur    [Steps];
  div_st_t          nxt    [Steps];
  div_st_t          init;

  always_comb begin
    init.sel = st_i.sel;
    init.ok  = st_i.ok;
    init.den = st_i.den;
    init.rem = NumW'(st_i.prod[ProdW-1:QuoW]);
    init.low = st_i.prod[QuoW-1:0];
    init.quo = '0;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [NumW:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign cur[k] = init;
    end else begin : g_next
      assign cur[k] = st_q[k-1];
    end

    always_comb begin
      trial      = {cur[k].rem, cur[k].low[QuoW-1]};
      ge         = trial >= {1'b0, cur[k].den};
      nxt[k]     = cur[k];
      nxt[k].rem = ge ? NumW'(trial - {1'b0, cur[k].den}) : trial[NumW-1:0];
      nxt[k].low = {cur[k].low[QuoW-2:0], 1'b0};
      nxt[k].quo = {cur[k].quo[QuoW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign st_o    = st_q[Steps-1];

  // The partial remainder of a live, in-range item stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Steps-1] && st_q[Steps-1].ok |-> st_q[Steps-1].rem < st_q[Steps-1].den)
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/autorange_resistance_calc_unit.sv -----
// ----------------------------------------------------------------------------
// autorange_resistance_calc_unit: autoranging ohmmeter resistance path
// Turns one set of ADC codes into a range index, a resistance in tenths of
// an ohm and a display unit class.
// ----------------------------------------------------------------------------
// Usage:
//   meas_i carries one measurement set per request: the reference code and
//   seven range codes. res_o returns one result per request, in order.
//   cfg_i writes the divider and range registers; it is always ready, and
//   registers should only be written while no request is in flight.
//   The unit is a single pipeline of 31 register stages: range selection,
//   two product stages, a difference stage, an overflow test, 25 divider
//   stages (one quotient bit each) and the output register. One request can be
//   accepted every cycle while the output side does not stall the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and meas_i.ready drops, so nothing is lost or repeated. While the
//   output register is empty or being drained, meas_i.ready stays high.
//   Reset clears all stage valid bits and loads the registers with their
//   default divider and range values; no result is shown after reset.
// ----------------------------------------------------------------------------
module autorange_resistance_calc_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rclc_stream_if.sink   meas_i,
  rclc_stream_if.source res_o,
  rclc_stream_if.sink   cfg_i
);
  import rclc_pkg::*;

  cfg_t     cfg;
  logic     adv;
  logic     sel_valid, ar_valid, div_valid;
  sel_st_t  sel_st;
  prod_st_t ar_st;
  div_st_t  div_st;

  logic     out_valid_q;
  result_t  out_q, out_d;
  logic     in_range;

  // The pipeline moves as one whenever the output register can take a value.
  assign adv          = !out_valid_q || res_o.ready;
  assign meas_i.ready = adv;

  rclc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rclc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (meas_i.valid),
    .meas_i  (meas_i.payload),
    .cfg_i   (cfg),
    .valid_o (sel_valid),
    .st_o    (sel_st)
  );

  rclc_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sel_valid),
    .st_i    (sel_st),
    .cfg_i   (cfg),
    .valid_o (ar_valid),
    .st_o    (ar_st)
  );

  rclc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ar_valid),
    .st_i    (ar_st),
    .valid_o (div_valid),
    .st_o    (div_st)
  );

  // The upper limit is inclusive only for an exact quotient, since the
  // comparison is against the untruncated ratio.
  always_comb begin
    in_range = div_st.ok && (div_st.quo >= MinTenths) &&
               ((div_st.quo < MaxTenths) ||
                ((div_st.quo == MaxTenths) && (div_st.rem == '0)));

    out_d.chosen_range      = div_st.sel;
    out_d.resistance_tenths = in_range ? div_st.quo : '0;
    if (!in_range) begin
      out_d.unit_class = UnitInvalid;
    end else if (div_st.quo < OhmDecLimit) begin
      out_d.unit_class = UnitOhmDec;
    end else if (div_st.quo < OhmLimit) begin
      out_d.unit_class = UnitOhm;
    end else if (div_st.quo < KohmLimit) begin
      out_d.unit_class = UnitKohm;
    end else begin
      out_d.unit_class = UnitMohm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  // Input acceptance follows the output side exactly.
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_i.ready == (!res_o.valid || res_o.ready))
    else $error("input ready does not follow output stall");

  // An invalid class always comes with a zero value.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.payload.unit_class == UnitInvalid)
      |-> res_o.payload.resistance_tenths == '0)
    else $error("invalid result with nonzero resistance");

  // A valid class always comes with a value inside the limits.
  a_valid_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.payload.unit_class != UnitInvalid)
      |-> (res_o.payload.resistance_tenths >= MinTenths) &&
          (res_o.payload.resistance_tenths <= MaxTenths))
    else $error("valid result outside limits");

  // A stalled result is held over into the next cycle.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.payload))
    else $error("stalled result changed");

endmodule
